@@ hw/rtl/code_point_to_byte_encoder_assert.svh @@
// assertion macros shared by the encoder checks
`ifndef CODE_POINT_TO_BYTE_ENCODER_ASSERT_SVH
`define CODE_POINT_TO_BYTE_ENCODER_ASSERT_SVH

// same-cycle implication, off while reset is held
`define CPBE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CPBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cpbe_pkg.sv @@
// shared types and constants of the code point to byte encoder
package cpbe_pkg;

    localparam int unsigned CPBE_CP_W    = 21;
    localparam int unsigned CPBE_MODE_W  = 3;
    localparam int unsigned CPBE_QDEPTH  = 4;

    localparam logic [CPBE_MODE_W-1:0] MODE_ASCII   = 3'd0;
    localparam logic [CPBE_MODE_W-1:0] MODE_LATIN1  = 3'd1;
    localparam logic [CPBE_MODE_W-1:0] MODE_UTF8    = 3'd2;
    localparam logic [CPBE_MODE_W-1:0] MODE_UTF16LE = 3'd3;
    localparam logic [CPBE_MODE_W-1:0] MODE_UTF16BE = 3'd4;

    // one classified item: its bytes in output order and the index of the last one
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            invalid;
    } t_entry;

endpackage

@@ hw/rtl/code_point_to_byte_encoder.sv @@
// top level of the code point to byte encoder
// An item is taken at each edge where start is high and busy is low; the
// front end classifies it at once and queues its byte list, and the back
// end sends one byte per clock on o_out_byte with o_strobe high, the last
// byte of the item marked by o_last_byte. An item is sent as one byte in
// ascii and iso-8859-1 mode, one to four bytes in utf-8, two or four in
// utf-16, and one for an item that cannot be encoded (o_invalid_char high,
// byte zero), all through the single byte-wide output port. The first byte
// of an item is written into the queue when it is taken, then registered
// in the back end driving the outputs; queued items ahead go out before
// that. Items may be started back to back; busy rises only when the queue
// of QDEPTH items is full. The receiver cannot stall: every strobed byte
// must be taken in its cycle. Write i_cfg_wdata (0 ascii, 1 iso-8859-1,
// 2 utf-8, 3 utf-16le, 4 utf-16be, others reject everything) only while no
// item is in flight; reset selects utf-8.
module code_point_to_byte_encoder
    import cpbe_pkg::*;
#(
    parameter int unsigned QDEPTH = CPBE_QDEPTH
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CPBE_MODE_W-1:0] i_cfg_wdata,
    input  logic                   start,
    output logic                   busy,
    input  logic [CPBE_CP_W-1:0]   i_code_point,
    output logic                   o_strobe,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_byte,
    output logic                   o_invalid_char
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;

    assign busy = q_full;

    cpbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_start      (start),
        .i_code_point (i_code_point),
        .i_full       (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    cpbe_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cpbe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (head_entry),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte),
        .o_invalid_char (o_invalid_char)
    );

endmodule

@@ hw/rtl/cpbe_front.sv @@
// front end: mode register, item accept and classification into byte lists
module cpbe_front
    import cpbe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CPBE_MODE_W-1:0] i_cfg_wdata,
    input  logic                   i_start,
    input  logic [CPBE_CP_W-1:0]   i_code_point,
    input  logic                   i_full,
    output logic                   o_push,
    output t_entry                 o_entry
);

    logic [CPBE_MODE_W-1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UTF8;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign o_push = i_start && !i_full;

    always_comb begin
        logic [CPBE_CP_W-1:0] cp;
        logic [CPBE_CP_W-1:0] v;
        logic [15:0]          unit_hi;
        logic [15:0]          unit_lo;
        logic                 big;
        cp      = i_code_point;
        v       = cp - 21'h010000;
        unit_hi = 16'hd800 | {6'd0, v[19:10]};
        unit_lo = 16'hdc00 | {6'd0, v[9:0]};
        big     = (r_mode == MODE_UTF16BE);
        o_entry = '0;
        case (r_mode)
            MODE_ASCII: begin
                if (cp > 21'h00007f) begin
                    o_entry.invalid = 1'b1;
                end else begin
                    o_entry.bytes[0] = cp[7:0];
                end
            end
            MODE_LATIN1: begin
                if (cp > 21'h0000ff) begin
                    o_entry.invalid = 1'b1;
                end else begin
                    o_entry.bytes[0] = cp[7:0];
                end
            end
            MODE_UTF8: begin
                if (cp <= 21'h00007f) begin
                    o_entry.bytes[0] = cp[7:0];
                end else if (cp <= 21'h0007ff) begin
                    o_entry.bytes[0] = {3'b110, cp[10:6]};
                    o_entry.bytes[1] = {2'b10, cp[5:0]};
                    o_entry.last_idx = 2'd1;
                end else if (cp <= 21'h00ffff) begin
                    o_entry.bytes[0] = {4'b1110, cp[15:12]};
                    o_entry.bytes[1] = {2'b10, cp[11:6]};
                    o_entry.bytes[2] = {2'b10, cp[5:0]};
                    o_entry.last_idx = 2'd2;
                end else if (cp <= 21'h10ffff) begin
                    o_entry.bytes[0] = {5'b11110, cp[20:18]};
                    o_entry.bytes[1] = {2'b10, cp[17:12]};
                    o_entry.bytes[2] = {2'b10, cp[11:6]};
                    o_entry.bytes[3] = {2'b10, cp[5:0]};
                    o_entry.last_idx = 2'd3;
                end else begin
                    o_entry.invalid = 1'b1;
                end
            end
            MODE_UTF16LE, MODE_UTF16BE: begin
                if (cp <= 21'h00ffff) begin
                    o_entry.bytes[0] = big ? cp[15:8] : cp[7:0];
                    o_entry.bytes[1] = big ? cp[7:0]  : cp[15:8];
                    o_entry.last_idx = 2'd1;
                end else if (cp <= 21'h10ffff) begin
                    // surrogate pair, high unit first
                    o_entry.bytes[0] = big ? unit_hi[15:8] : unit_hi[7:0];
                    o_entry.bytes[1] = big ? unit_hi[7:0]  : unit_hi[15:8];
                    o_entry.bytes[2] = big ? unit_lo[15:8] : unit_lo[7:0];
                    o_entry.bytes[3] = big ? unit_lo[7:0]  : unit_lo[15:8];
                    o_entry.last_idx = 2'd3;
                end else begin
                    o_entry.invalid = 1'b1;
                end
            end
            default: begin
                o_entry.invalid = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/cpbe_queue.sv @@
// small queue of classified items between front and back end
module cpbe_queue
    import cpbe_pkg::*;
#(
    parameter int unsigned QDEPTH = CPBE_QDEPTH
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty,
    output logic   o_full
);

    localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CW = $clog2(QDEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_entry        r_store [QDEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_entry = r_store[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ hw/rtl/cpbe_back.sv @@
// back end: sends the bytes of the head item one per cycle
module cpbe_back
    import cpbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic       o_invalid_char
);

    logic [1:0] r_idx;
    logic       r_strobe;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_invalid;
    logic       is_last;

    assign is_last = (r_idx == i_entry.last_idx);
    assign o_pop   = !i_empty && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= !i_empty;
            if (!i_empty) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= i_entry.bytes[r_idx];
        r_last    <= is_last;
        r_invalid <= i_entry.invalid;
    end

    assign o_strobe       = r_strobe;
    assign o_out_byte     = r_byte;
    assign o_last_byte    = r_last;
    assign o_invalid_char = r_invalid;

endmodule

@@ hw/rtl/cpbe_checker.sv @@
// port-level checks of the encoder and their binding to the top level
`include "code_point_to_byte_encoder_assert.svh"

module cpbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_out_byte,
    input logic       o_last_byte,
    input logic       o_invalid_char
);

    // a rejected item is a single zero byte
    `CPBE_ASSERT_NOW(a_invalid_single, i_clk, i_rst_n, o_strobe && o_invalid_char, o_last_byte && (o_out_byte == 8'd0), "invalid item not a single zero byte")

    // bytes of one item go out in consecutive cycles
    `CPBE_ASSERT_NEXT(a_item_contiguous, i_clk, i_rst_n, o_strobe && !o_last_byte, o_strobe, "gap inside an item")

    // only the last byte of an item may carry the error flag
    `CPBE_ASSERT_NOW(a_invalid_last, i_clk, i_rst_n, o_strobe && !o_last_byte, !o_invalid_char, "error flag on a middle byte")

    // a full queue always has a byte going out next cycle
    `CPBE_ASSERT_NEXT(a_busy_drains, i_clk, i_rst_n, busy, o_strobe, "busy without output")

endmodule

bind code_point_to_byte_encoder cpbe_checker u_cpbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_out_byte     (o_out_byte),
    .o_last_byte    (o_last_byte),
    .o_invalid_char (o_invalid_char)
);

@@ tb/sv/cpbe_byte_checker.sv @@
// byte stream predictor and comparator for the code point to byte encoder
module cpbe_byte_checker
    import cpbe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CPBE_MODE_W-1:0] i_cfg_wdata,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [CPBE_CP_W-1:0]   i_code_point,
    input  logic                   i_strobe,
    input  logic [7:0]             i_out_byte,
    input  logic                   i_last_byte,
    input  logic                   i_invalid_char,
    output int unsigned            o_fail_count,
    output int unsigned            o_pending_bytes,
    output int unsigned            o_bytes_checked
);

    typedef struct packed {
        logic [7:0] ob_byte;
        logic       ob_last;
        logic       ob_bad;
    } t_enc_byte;

    t_enc_byte                expected_bytes[$];
    logic [CPBE_MODE_W-1:0]   enc_mode;

    // queues the byte sequence that one code point turns into under a mode
    function automatic void predict_bytes(input logic [CPBE_MODE_W-1:0] mode,
                                          input logic [CPBE_CP_W-1:0] cp);
        logic [7:0]  b [4];
        logic [20:0] offs;
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
        int          n;
        n = 0;
        unit_hi = '0;
        unit_lo = '0;
        case (mode)
            MODE_ASCII: begin
                if (cp <= 21'h7f) begin
                    b[0] = cp[7:0];
                    n = 1;
                end
            end
            MODE_LATIN1: begin
                if (cp <= 21'hff) begin
                    b[0] = cp[7:0];
                    n = 1;
                end
            end
            MODE_UTF8: begin
                if (cp <= 21'h7f) begin
                    b[0] = cp[7:0];
                    n = 1;
                end else if (cp <= 21'h7ff) begin
                    b[0] = {3'b110, cp[10:6]};
                    b[1] = {2'b10, cp[5:0]};
                    n = 2;
                end else if (cp <= 21'hffff) begin
                    b[0] = {4'b1110, cp[15:12]};
                    b[1] = {2'b10, cp[11:6]};
                    b[2] = {2'b10, cp[5:0]};
                    n = 3;
                end else if (cp <= 21'h10ffff) begin
                    b[0] = {5'b11110, cp[20:18]};
                    b[1] = {2'b10, cp[17:12]};
                    b[2] = {2'b10, cp[11:6]};
                    b[3] = {2'b10, cp[5:0]};
                    n = 4;
                end
            end
            MODE_UTF16LE, MODE_UTF16BE: begin
                if (cp <= 21'hffff) begin
                    unit_hi = cp[15:0];
                    n = 2;
                end else if (cp <= 21'h10ffff) begin
                    offs = cp - 21'h10000;
                    unit_hi = {6'b110110, offs[19:10]};
                    unit_lo = {6'b110111, offs[9:0]};
                    n = 4;
                end
                // each 16-bit unit goes out in the selected byte order
                if (mode == MODE_UTF16BE) begin
                    b[0] = unit_hi[15:8];
                    b[1] = unit_hi[7:0];
                    b[2] = unit_lo[15:8];
                    b[3] = unit_lo[7:0];
                end else begin
                    b[0] = unit_hi[7:0];
                    b[1] = unit_hi[15:8];
                    b[2] = unit_lo[7:0];
                    b[3] = unit_lo[15:8];
                end
            end
            default: n = 0;
        endcase
        if (n == 0) begin
            expected_bytes.push_back('{ob_byte: 8'h00, ob_last: 1'b1, ob_bad: 1'b1});
        end else begin
            for (int i = 0; i < n; i++)
                expected_bytes.push_back('{ob_byte: b[i], ob_last: (i == n - 1), ob_bad: 1'b0});
        end
    endfunction

    always @(posedge i_clk) begin
        t_enc_byte exp_b;
        if (!i_rst_n) begin
            expected_bytes.delete();
            enc_mode = MODE_UTF8;
            o_fail_count = 0;
            o_bytes_checked = 0;
        end else begin
            // results first: an item taken at this edge cannot produce a byte yet
            if (i_strobe) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte 0x%02h (last %0b, invalid %0b)",
                           i_out_byte, i_last_byte, i_invalid_char);
                    o_fail_count++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    o_bytes_checked++;
                    if (i_out_byte !== exp_b.ob_byte) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               exp_b.ob_byte, i_out_byte);
                        o_fail_count++;
                    end
                    if (i_last_byte !== exp_b.ob_last) begin
                        $error("last_byte: expected %0b, got %0b", exp_b.ob_last, i_last_byte);
                        o_fail_count++;
                    end
                    if (i_invalid_char !== exp_b.ob_bad) begin
                        $error("invalid_char: expected %0b, got %0b",
                               exp_b.ob_bad, i_invalid_char);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                predict_bytes(enc_mode, i_code_point);
            if (i_cfg_we)
                enc_mode = i_cfg_wdata;
        end
        o_pending_bytes = expected_bytes.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// top of the encoder testbench: clock, reset, code point stimulus and verdict
module tb;
    import cpbe_pkg::*;

    // encodings the block has no use for; every item is rejected under them
    localparam logic [CPBE_MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [CPBE_MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [CPBE_MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 35;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CPBE_MODE_W-1:0] i_cfg_wdata;
    logic                   start;
    logic                   busy;
    logic [CPBE_CP_W-1:0]   i_code_point;
    logic                   o_strobe;
    logic [7:0]             o_out_byte;
    logic                   o_last_byte;
    logic                   o_invalid_char;

    int unsigned fail_count;
    int unsigned pending_bytes;
    int unsigned bytes_checked;
    int unsigned idle_pct;
    int unsigned items_sent;

    logic [CPBE_MODE_W-1:0] phase_modes [PHASES] = '{
        MODE_UTF8, MODE_ASCII, MODE_UTF16LE, MODE_LATIN1, MODE_UTF16BE,
        MODE_SPARE_7, MODE_SPARE_6, MODE_UTF8, MODE_UTF16LE, MODE_UTF16BE
    };

    code_point_to_byte_encoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_code_point   (i_code_point),
        .o_strobe       (o_strobe),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte),
        .o_invalid_char (o_invalid_char)
    );

    cpbe_byte_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (start),
        .i_busy          (busy),
        .i_code_point    (i_code_point),
        .i_strobe        (o_strobe),
        .i_out_byte      (o_out_byte),
        .i_last_byte     (o_last_byte),
        .i_invalid_char  (o_invalid_char),
        .o_fail_count    (fail_count),
        .o_pending_bytes (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic wait_drained();
        while (pending_bytes != 0) @(negedge i_clk);
    endtask

    // called at a falling edge; the mode only changes once the output is quiet
    task automatic set_mode(input logic [CPBE_MODE_W-1:0] mode);
        start <= 1'b0;
        @(negedge i_clk);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // offers one item and returns at the falling edge after it was taken
    task automatic send_code_point(input logic [CPBE_CP_W-1:0] cp);
        bit hold;
        int gap;
        hold = ($urandom_range(39) == 0);
        gap  = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (hold || gap > 0) begin
            start <= 1'b0;
            repeat ((gap > 0) ? gap : 1) @(negedge i_clk);
            if (hold)
                wait_drained();
        end
        start        <= 1'b1;
        i_code_point <= cp;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        items_sent++;
    endtask

    function automatic logic [CPBE_CP_W-1:0] random_code_point();
        logic [CPBE_CP_W-1:0] cp;
        case ($urandom_range(9))
            0: cp = CPBE_CP_W'($urandom_range(21'h7f));
            1: cp = CPBE_CP_W'($urandom_range(21'hff, 21'h80));
            2: cp = CPBE_CP_W'($urandom_range(21'h7ff, 21'h100));
            3: cp = CPBE_CP_W'($urandom_range(21'hffff, 21'h800));
            4: cp = CPBE_CP_W'($urandom_range(21'hdfff, 21'hd800));
            5: cp = CPBE_CP_W'($urandom_range(21'h10ffff, 21'h10000));
            6: cp = CPBE_CP_W'($urandom_range(21'h1fffff, 21'h110000));
            7: cp = CPBE_CP_W'($urandom());
            default: begin
                // edges between byte counts and ranges
                case ($urandom_range(11))
                    0: cp = 21'h0;
                    1: cp = 21'h7f;
                    2: cp = 21'h80;
                    3: cp = 21'hff;
                    4: cp = 21'h100;
                    5: cp = 21'h7ff;
                    6: cp = 21'h800;
                    7: cp = 21'hffff;
                    8: cp = 21'h10000;
                    9: cp = 21'h10ffff;
                    10: cp = 21'h110000;
                    default: cp = 21'h1fffff;
                endcase
            end
        endcase
        return cp;
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = MODE_UTF8;
        start        = 1'b0;
        i_code_point = '0;
        idle_pct     = 0;
        items_sent   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // utf-8 straight out of reset, across every length boundary
        send_code_point(21'h0);
        send_code_point(21'h7f);
        send_code_point(21'h80);
        send_code_point(21'h7ff);
        send_code_point(21'h800);
        send_code_point(21'hd800);
        send_code_point(21'hffff);
        send_code_point(21'h10000);
        send_code_point(21'h10ffff);
        send_code_point(21'h110000);
        set_mode(MODE_ASCII);
        send_code_point(21'h7f);
        send_code_point(21'h80);
        set_mode(MODE_LATIN1);
        send_code_point(21'hff);
        send_code_point(21'h100);
        set_mode(MODE_UTF16LE);
        send_code_point(21'h0);
        send_code_point(21'hdfff);
        send_code_point(21'h10000);
        send_code_point(21'h10ffff);
        send_code_point(21'h110000);
        set_mode(MODE_UTF16BE);
        send_code_point(21'hffff);
        send_code_point(21'h10000);
        send_code_point(21'h1fffff);
        set_mode(MODE_SPARE_7);
        send_code_point(21'h0);
        set_mode(MODE_SPARE_5);
        send_code_point(21'h41);

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct = (ph < 4) ? 33 : (ph < 7) ? 50 : 0;
            set_mode(phase_modes[ph]);
            repeat (ITEMS_PER_PHASE) send_code_point(random_code_point());
        end

        start <= 1'b0;
        for (int n = 0; n < 2000 && pending_bytes != 0; n++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("sent %0d code points over all eight mode values, %0d bytes compared",
                 items_sent, bytes_checked);
        $display("boundaries, surrogates and out of range values under three idle profiles");
        if (fail_count == 0 && pending_bytes == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_bytes != 0)
                $error("%0d expected bytes never arrived", pending_bytes);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ code_point_to_byte_encoder.f @@
+incdir+hw/rtl
hw/rtl/cpbe_pkg.sv
hw/rtl/cpbe_front.sv
hw/rtl/cpbe_queue.sv
hw/rtl/cpbe_back.sv
hw/rtl/code_point_to_byte_encoder.sv
hw/rtl/cpbe_checker.sv
tb/sv/cpbe_byte_checker.sv
tb/sv/tb.sv
